// File: rtl/hzcd_pkg.sv
// Shared constants for the heartbeat zero-crossing detector.
// Used by the top level, its bound checker and the testbench; no dependencies.
package hzcd_pkg;

   // Field widths of the stream beats and registers
   localparam int SLOPE_W    = 24;
   localparam int TIME_W     = 32;
   localparam int RATE_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   // Default dividend of the rate computation (ms per minute)
   localparam int RATE_NUMERATOR_DEF = 60000;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EARLY   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd4;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_INTERVAL   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_LOW       = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_HIGH      = 8'd3;

   // Register reset values
   localparam logic signed [SLOPE_W-1:0] EDGE_THRESHOLD_RST = -24'sd2000;
   localparam logic [RATE_W-1:0]         MIN_INTERVAL_RST   = 16'd300;
   localparam logic [RATE_W-1:0]         RATE_LOW_RST       = 16'd20;
   localparam logic [RATE_W-1:0]         RATE_HIGH_RST      = 16'd250;

endpackage

// File: rtl/heartbeat_zero_cross_detector.sv
// Heartbeat zero-crossing detector: beat detection and serial rate divider.
// Depends on hzcd_pkg.
//
// Usage:
//   req channel: one differentiated pulse sample per beat. tdata holds slope
//   (24 bit signed) then time_ms (32 bit); tuser holds slope_valid.
//   rsp channel: exactly one result per input beat. tdata holds rate_bpm,
//   tuser holds status (0 none, 1 accepted, 2 out of window, 3 first or too
//   soon, 4 invalid slope).
//   csr channel: register index and write data, always ready; write only
//   while no sample is in flight.
// Sequence: a sample without a rate goes from capture through the EVAL and
//   SEND states into the output register. A beat that needs a rate runs a
//   restoring divider, one quotient bit per cycle, over clog2(RATE_NUMERATOR+1)
//   quotient bits (16 at the default), then the RATE state, before SEND.
// Flow: one sample at a time; req_tready is high only while the sequencer is
//   idle, so a new sample waits until the last result is in the output register.
// Reset: registers return to their defaults, the detector is disarmed and no
//   beat is on record; req_tready is high as soon as reset is released.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next sample is still taken and holds in the sequencer until it frees.
module heartbeat_zero_cross_detector
   import hzcd_pkg::*;
#(
   parameter int RATE_NUMERATOR = RATE_NUMERATOR_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: slope [23:0], time_ms [55:24]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,
   // req_tuser: slope_valid [0]
   input  logic                  req_tuser,
   // rsp_tdata: rate_bpm [15:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RATE_W-1:0]     rsp_tdata,
   // rsp_tuser: status [2:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NUM_W = $clog2(RATE_NUMERATOR + 1);
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [NUM_W-1:0] NUM_BITS = NUM_W'(RATE_NUMERATOR);
   localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(NUM_W - 1);

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_RATE = 3'd3;
   localparam logic [2:0] ST_SEND = 3'd4;

   logic [2:0] state_ff, state_in;

   // Configuration registers
   logic signed [SLOPE_W-1:0] edge_thr_ff;
   logic [RATE_W-1:0]         min_int_ff, rate_low_ff, rate_high_ff;

   // Captured sample
   logic signed [SLOPE_W-1:0] cur_slope_ff;
   logic                      cur_valid_ff;
   logic [TIME_W-1:0]         now_ff;

   // Detector state
   logic signed [SLOPE_W-1:0] prev_slope_ff, prev_slope_in;
   logic                      prev_valid_ff, prev_valid_in;
   logic                      armed_ff, armed_in;
   logic [TIME_W-1:0]         cross_time_ff, cross_time_in;
   logic [TIME_W-1:0]         last_beat_ff, last_beat_in;

   // Divider
   logic [NUM_W-1:0]  div_rem_ff, div_rem_in;
   logic [NUM_W-1:0]  div_quo_ff, div_quo_in;
   logic [TIME_W-1:0] div_den_ff, div_den_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   // Pending result and output register
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [RATE_W-1:0]   res_rate_ff, res_rate_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [RATE_W-1:0]   rsp_rate_ff;

   logic req_acc, csr_acc, out_free;

   // Evaluation terms
   logic              both_valid, crossing, armed_a, beat;
   logic [TIME_W-1:0] cross_a, interval;

   // Divider step terms
   logic [NUM_W:0]    trial;
   logic [TIME_W-1:0] trial_ext, diff;
   logic              fits;
   logic [RATE_W-1:0] quo_rate;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign csr_acc    = csr_valid & csr_ready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rate_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_thr_ff  <= EDGE_THRESHOLD_RST;
         min_int_ff   <= MIN_INTERVAL_RST;
         rate_low_ff  <= RATE_LOW_RST;
         rate_high_ff <= RATE_HIGH_RST;
      end else if (csr_acc) begin
         case (csr_index)
            REG_EDGE_THRESHOLD: edge_thr_ff  <= csr_data;
            REG_MIN_INTERVAL:   min_int_ff   <= csr_data[RATE_W-1:0];
            REG_RATE_LOW:       rate_low_ff  <= csr_data[RATE_W-1:0];
            REG_RATE_HIGH:      rate_high_ff <= csr_data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sample capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cur_slope_ff <= req_tdata[SLOPE_W-1:0];
         now_ff       <= req_tdata[SLOPE_W +: TIME_W];
         cur_valid_ff <= req_tuser;
      end
   end

   // Crossing and beat decision
   always_comb begin
      both_valid = cur_valid_ff & prev_valid_ff;
      crossing   = (prev_slope_ff > 24'sd0) && (cur_slope_ff < 24'sd0);
      armed_a    = crossing | armed_ff;
      cross_a    = crossing ? now_ff : cross_time_ff;
      if (cur_slope_ff > 24'sd0) begin
         armed_a = 1'b0;
      end
      beat     = armed_a && (cur_slope_ff < edge_thr_ff);
      interval = cross_a - last_beat_ff;
   end

   // One restoring divider step
   always_comb begin
      trial     = {div_rem_ff, NUM_BITS[div_cnt_ff]};
      trial_ext = TIME_W'(trial);
      fits      = (trial_ext >= div_den_ff);
      diff      = trial_ext - div_den_ff;
      quo_rate  = RATE_W'(div_quo_ff);
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      prev_slope_in = prev_slope_ff;
      prev_valid_in = prev_valid_ff;
      armed_in      = armed_ff;
      cross_time_in = cross_time_ff;
      last_beat_in  = last_beat_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_den_in    = div_den_ff;
      div_cnt_in    = div_cnt_ff;
      res_status_in = res_status_ff;
      res_rate_in   = res_rate_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            prev_slope_in = cur_slope_ff;
            prev_valid_in = cur_valid_ff;
            res_rate_in   = '0;
            state_in      = ST_SEND;
            if (!both_valid) begin
               res_status_in = STATUS_INVALID;
            end else begin
               armed_in      = armed_a & ~beat;
               cross_time_in = cross_a;
               res_status_in = STATUS_NONE;
               if (beat) begin
                  last_beat_in = cross_a;
                  if ((last_beat_ff != '0) && (interval > TIME_W'(min_int_ff))) begin
                     div_rem_in = '0;
                     div_quo_in = '0;
                     div_den_in = interval;
                     div_cnt_in = CNT_TOP;
                     state_in   = ST_DIV;
                  end else begin
                     res_status_in = STATUS_EARLY;
                  end
               end
            end
         end
         ST_DIV: begin
            div_rem_in = fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
            div_quo_in = {div_quo_ff[NUM_W-2:0], fits};
            div_cnt_in = div_cnt_ff - CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            res_rate_in   = quo_rate;
            res_status_in = ((quo_rate > rate_low_ff) && (quo_rate < rate_high_ff))
                            ? STATUS_ACCEPT : STATUS_RANGE;
            state_in      = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         prev_slope_ff <= '0;
         prev_valid_ff <= 1'b0;
         armed_ff      <= 1'b0;
         cross_time_ff <= '0;
         last_beat_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_slope_ff <= prev_slope_in;
         prev_valid_ff <= prev_valid_in;
         armed_ff      <= armed_in;
         cross_time_ff <= cross_time_in;
         last_beat_ff  <= last_beat_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_den_ff    <= div_den_in;
      div_cnt_ff    <= div_cnt_in;
      res_status_ff <= res_status_in;
      res_rate_ff   <= res_rate_in;
      if ((state_ff == ST_SEND) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_rate_ff   <= res_rate_ff;
      end
   end

endmodule

// File: rtl/hzcd_check.sv
// Port-level checker for the heartbeat zero-crossing detector, with its bind.
// Depends on hzcd_pkg and heartbeat_zero_cross_detector.
module hzcd_check
   import hzcd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RATE_W-1:0]   rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // Status stays within the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= STATUS_INVALID)
      else $error("undefined status code");

   // Rate is reported only with a computed rate
   a_rate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_ACCEPT) && (rsp_tuser != STATUS_RANGE)
      |-> rsp_tdata == '0)
      else $error("rate set without a rate status");

   // An accepted sample keeps the block busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting a sample");

endmodule

bind heartbeat_zero_cross_detector hzcd_check u_hzcd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/tb.sv
// Self-checking testbench for heartbeat_zero_cross_detector: random and directed
// pulse samples, a scoreboard that predicts status and rate per sample.
// Depends on hzcd_pkg and the detector RTL.
module tb;
   import hzcd_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 115;
   localparam int NUM_PHASES    = 8;
   localparam int REG_COUNT     = 4;
   localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 24'sh800000;
   localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 24'sh7FFFFF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RATE_W-1:0]   rate;
   } beat_result_type;

   // Predicts one result per sample and checks results in order
   class beat_scoreboard_type;
      logic signed [SLOPE_W-1:0] edge_thr;
      logic [RATE_W-1:0]         min_ivl, rate_lo, rate_hi;
      logic signed [SLOPE_W-1:0] prev_slope;
      bit                        prev_ok, armed;
      logic [TIME_W-1:0]         cross_t, last_beat_t;
      beat_result_type           pending[$];
      int                        errors;

      function new();
         edge_thr    = EDGE_THRESHOLD_RST;
         min_ivl     = MIN_INTERVAL_RST;
         rate_lo     = RATE_LOW_RST;
         rate_hi     = RATE_HIGH_RST;
         prev_slope  = '0;
         prev_ok     = 1'b0;
         armed       = 1'b0;
         cross_t     = '0;
         last_beat_t = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_EDGE_THRESHOLD: edge_thr = data;
            REG_MIN_INTERVAL:   min_ivl  = data[RATE_W-1:0];
            REG_RATE_LOW:       rate_lo  = data[RATE_W-1:0];
            REG_RATE_HIGH:      rate_hi  = data[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [SLOPE_W-1:0] cur, bit ok,
                                logic [TIME_W-1:0] now);
         beat_result_type   r;
         logic [TIME_W-1:0] ivl, quot;
         r.status = STATUS_NONE;
         r.rate   = '0;
         if (ok && prev_ok) begin
            // positive-to-negative crossing arms, any positive slope disarms
            if (prev_slope > 0 && cur < 0) begin
               armed   = 1'b1;
               cross_t = now;
            end
            if (cur > 0)
               armed = 1'b0;
            if (armed && cur < edge_thr) begin
               ivl = cross_t - last_beat_t;
               if (last_beat_t != 0 && ivl > min_ivl) begin
                  quot     = TIME_W'(RATE_NUMERATOR_DEF) / ivl;
                  r.rate   = quot[RATE_W-1:0];
                  r.status = (r.rate > rate_lo && r.rate < rate_hi) ?
                             STATUS_ACCEPT : STATUS_RANGE;
               end else begin
                  r.status = STATUS_EARLY;
               end
               armed       = 1'b0;
               last_beat_t = cross_t;
            end
         end else begin
            r.status = STATUS_INVALID;
         end
         prev_slope = cur;
         prev_ok    = ok;
         pending.push_back(r);
      endfunction

      function void check_result(logic [STATUS_W-1:0] st, logic [RATE_W-1:0] rate);
         beat_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d rate %0d",
                     $time, st, rate);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (st !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, st);
            errors++;
         end
         if (rate !== want.rate) begin
            $display("%0t: rate mismatch, expected %0d actual %0d",
                     $time, want.rate, rate);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;    // slope [23:0], time_ms [55:24]
   logic                  req_tuser = 1'b0;  // slope_valid [0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RATE_W-1:0]     rsp_tdata;         // rate_bpm [15:0]
   logic [STATUS_W-1:0]   rsp_tuser;         // status [2:0]
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   beat_scoreboard_type sb = new();
   int                  tx_burst = 0;
   int                  rx_burst = 0;
   int                  n_sent = 0;
   int                  idle_cycles = 0;
   bit                  hold_pending = 1'b0;
   logic [TIME_W-1:0]   gen_cross = '0;

   heartbeat_zero_cross_detector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Watchdog: ends the run when no channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Wait per beat: mostly a random wait, with occasional runs of no waiting
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = int'($urandom_range(10, 40));
         return 0;
      end
      return int'($urandom_range(0, 19));
   endfunction

   // Slope below the edge threshold, often just below it; the most negative slope if the threshold is that
   function automatic logic signed [SLOPE_W-1:0] deep_slope();
      int thr;
      int span;
      thr = int'(sb.edge_thr);
      if (sb.edge_thr == SLOPE_MIN)
         return SLOPE_MIN;
      span = thr + 8388607;
      if ($urandom_range(0, 1))
         return SLOPE_W'(thr - 1 - int'($urandom_range(0, span)));
      return SLOPE_W'(thr - 1 - int'($urandom_range(0, (span < 64) ? span : 64)));
   endfunction

   // Negative slope at or above the threshold, zero if none exists
   function automatic logic signed [SLOPE_W-1:0] shallow_slope();
      int thr;
      thr = int'(sb.edge_thr);
      if (thr == 0)
         return '0;
      return SLOPE_W'(thr + int'($urandom_range(0, -1 - thr)));
   endfunction

   function automatic logic signed [SLOPE_W-1:0] pos_slope();
      if ($urandom_range(0, 3) == 0)
         return SLOPE_W'($urandom_range(1, 8388607));
      return SLOPE_W'($urandom_range(1, 5000));
   endfunction

   // Crossing-to-crossing spacing, often aimed at the interval and rate boundaries
   function automatic logic [TIME_W-1:0] pick_interval();
      int r;
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, sb.min_ivl + 1);
         1: return sb.min_ivl + $urandom_range(0, 2);
         2: begin
            r = (sb.rate_lo == 0) ? 60000 : 60000 / sb.rate_lo;
            return TIME_W'(r + int'($urandom_range(0, 4)) - 2);
         end
         3: begin
            r = (sb.rate_hi == 0) ? 60000 : 60000 / sb.rate_hi;
            return TIME_W'(r + int'($urandom_range(0, 4)) - 2);
         end
         4, 5: return $urandom_range(200, 3200);
         6: return $urandom;
         default: return $urandom_range(1, 70000);
      endcase
   endfunction

   task automatic send_sample(input logic signed [SLOPE_W-1:0] s, input bit ok,
                              input logic [TIME_W-1:0] t);
      int gap;
      gap = draw_wait(tx_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, s};
      req_tuser  <= ok;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(s, ok, t);
      n_sent++;
   endtask

   // Leaves csr_valid high so back-to-back writes need no second assignment
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Stop sending until every expected result is back, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One pulse: positive run, crossing, optional wobble, then the confirming edge
   task automatic beat_sequence();
      int                npos;
      logic [TIME_W-1:0] tc;
      npos = $urandom_range(1, 3);
      tc   = gen_cross + pick_interval();
      repeat (npos) send_sample(pos_slope(), 1'b1, tc - $urandom_range(1, 50));
      if ($urandom_range(0, 1)) begin
         send_sample(deep_slope(), 1'b1, tc);
      end else begin
         send_sample(shallow_slope(), 1'b1, tc);
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 9))
               0:       send_sample(SLOPE_W'($urandom), 1'b0, tc + $urandom_range(1, 30));
               1:       send_sample(pos_slope(), 1'b1, tc + $urandom_range(1, 30));
               2:       send_sample('0, 1'b1, tc + $urandom_range(1, 30));
               default: send_sample(shallow_slope(), 1'b1, tc + $urandom_range(1, 30));
            endcase
         end
         send_sample(deep_slope(), 1'b1, tc + $urandom_range(1, 30));
      end
      gen_cross = tc;
      // trailing samples after the edge: disarmed, no beat once the edge confirmed a beat
      repeat ($urandom_range(0, 2))
         send_sample($urandom_range(0, 1) ? deep_slope() : shallow_slope(), 1'b1,
                     tc + $urandom_range(31, 90));
   endtask

   task automatic apply_config(input int ph);
      logic signed [SLOPE_W-1:0] thr;
      logic [RATE_W-1:0]         mn, lo, hi;
      case (ph)
         1: begin
            thr = '0;
            mn  = '0;
            lo  = '0;
            hi  = '1;
         end
         2: begin
            thr = SLOPE_MIN;
            mn  = '1;
            lo  = '1;
            hi  = '0;
         end
         default: begin
            thr = SLOPE_W'(($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 8388608))
                                                       : -int'($urandom_range(0, 20000)));
            mn  = RATE_W'($urandom_range(0, 1000));
            lo  = RATE_W'($urandom_range(0, 120));
            hi  = RATE_W'(lo + $urandom_range(0, 400));
         end
      endcase
      wait_drained();
      write_csr(REG_EDGE_THRESHOLD, thr);
      write_csr(CSR_IDX_W'($urandom_range(REG_COUNT, 255)), CSR_DATA_W'($urandom));
      write_csr(REG_MIN_INTERVAL, {8'($urandom), mn});
      write_csr(REG_RATE_LOW, {8'($urandom), lo});
      write_csr(REG_RATE_HIGH, {8'($urandom), hi});
      csr_valid <= 1'b0;
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall        = hold_pending ? HOLD_CYCLES : draw_wait(rx_burst);
         hold_pending = 1'b0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // Stimulus
   initial begin : req_side
      int target;
      bit paused;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first sample after reset, then an edge with no beat on record
      send_sample(SLOPE_MAX, 1'b1, 32'd100);
      send_sample(SLOPE_MIN, 1'b1, 32'd110);
      // undefined sample, and the one after it
      send_sample('0, 1'b0, 32'd120);
      send_sample(-24'sd5000, 1'b1, 32'd130);
      // crossing at time zero before the last beat: wrapped interval, rate 0
      send_sample(24'sd1000, 1'b1, 32'd0);
      send_sample(-24'sd5000, 1'b1, 32'd0);
      // a beat recorded at time zero reads as no beat
      send_sample(24'sd1000, 1'b1, 32'd5);
      send_sample(-24'sd5000, 1'b1, 32'd1000);
      // too soon, in window, interval equal to the minimum, just above it
      send_sample(24'sd1000, 1'b1, 32'd1100);
      send_sample(-24'sd5000, 1'b1, 32'd1200);
      send_sample(24'sd1000, 1'b1, 32'd1300);
      send_sample(-24'sd5000, 1'b1, 32'd2200);
      send_sample(24'sd1000, 1'b1, 32'd2300);
      send_sample(-24'sd5000, 1'b1, 32'd2500);
      send_sample(24'sd1000, 1'b1, 32'd2600);
      send_sample(-24'sd5000, 1'b1, 32'd2801);
      // positive slope disarms; zero neither arms nor disarms
      send_sample(24'sd1000, 1'b1, 32'd3000);
      send_sample(-24'sd100, 1'b1, 32'd3100);
      send_sample(24'sd1000, 1'b1, 32'd3200);
      send_sample('0, 1'b1, 32'd3300);
      send_sample(-24'sd5000, 1'b1, 32'd3400);
      // stays armed across a zero; threshold itself does not confirm
      send_sample(24'sd1000, 1'b1, 32'd3500);
      send_sample(-24'sd100, 1'b1, 32'd4500);
      send_sample('0, 1'b1, 32'd4600);
      send_sample(-24'sd2000, 1'b1, 32'd4700);
      send_sample(-24'sd2001, 1'b1, 32'd4800);
      // slow rate out of window, then across the timestamp wrap
      send_sample(24'sd1000, 1'b1, 32'd7000);
      send_sample(-24'sd5000, 1'b1, 32'd8000);
      send_sample(24'sd1000, 1'b1, 32'hFFFF_FFF0);
      send_sample(-24'sd5000, 1'b1, 32'hFFFF_FFFF);
      send_sample(24'sd1000, 1'b1, 32'd600);
      send_sample(-24'sd5000, 1'b1, 32'd700);
      gen_cross = 32'd700;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0)
            apply_config(ph);
         if (ph == 3)
            hold_pending = 1'b1;
         paused = 1'b0;
         target = n_sent + PHASE_ITEMS;
         while (n_sent < target) begin
            // one drain pause mid-phase, in phase 5 only
            if (ph == 5 && !paused && n_sent >= target - PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            if ($urandom_range(0, 2) == 0)
               send_sample(SLOPE_W'($urandom), $urandom_range(0, 3) != 0, $urandom);
            else
               beat_sequence();
         end
      end

      wait_drained();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/hzcd_pkg.sv
rtl/heartbeat_zero_cross_detector.sv
rtl/hzcd_check.sv
tb/tb.sv
